// ===== design/sliding_window_capacity_penalty_core_macros.svh =====
// ============================================================================
// Assertion macros for the window penalty core
// Concurrent checks on clk, disabled while rst_n is low. Empty under
// synthesis.
// ============================================================================
`ifndef SLIDING_WINDOW_CAPACITY_PENALTY_CORE_MACROS_SVH
`define SLIDING_WINDOW_CAPACITY_PENALTY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// consequent in the same cycle
`define SWCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent in the following cycle
`define SWCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWCP_ASSERT_SAME(label, ante, cons, msg)
`define SWCP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/swcp_pkg.sv =====
// ============================================================================
// swcp_pkg
// Shared sizes, codes, control bundle and helpers of the window penalty core.
// ============================================================================
`default_nettype none

package swcp_pkg;

    localparam int STATIONS   = 5;
    localparam int MAX_JOBS   = 1024;
    localparam int LIMIT_BITS = 4;

    localparam int REG_W     = 20;
    localparam int PEN_W     = 20;
    localparam int MASK_W    = 5;
    localparam int SEQ_W     = 11;
    localparam int REQ_W     = 2;
    localparam int STS_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int EXC_W     = 6;
    localparam int EXC_MIN   = -(2 ** (EXC_W - 1));
    localparam int EXC_MAX   = 2 ** (EXC_W - 1) - 1;

    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int ADDR_W  = $clog2(MAX_JOBS);
    localparam int STA_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int SCNT_W  = $clog2(STATIONS + 1);
    localparam int IDX_W   = (SCNT_W > LIMIT_BITS) ? SCNT_W : LIMIT_BITS;
    localparam int LIM_MAX = 2 ** LIMIT_BITS - 1;
    // excess during tail walk or capacity shift: may fall by a full window
    localparam int FEXC_W  = $clog2(2 ** (EXC_W - 1) + 2 ** LIMIT_BITS) + 1;
    // sum of positive excesses over all stations
    localparam int SUM_W   = EXC_W - 1 + $clog2(STATIONS + 1);

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN = 1'd1;

    localparam logic [REG_W-1:0] CAP_RESET = 20'd69905;
    localparam logic [REG_W-1:0] WIN_RESET = 20'd139810;
    localparam logic [PEN_W-1:0] PEN_MAX   = '1;

    // sequencer to station datapath
    typedef struct packed {
        logic                  proc_vld;
        logic [REQ_W-1:0]      op;
        logic [STA_W-1:0]      sta;
        logic [LIMIT_BITS-1:0] step;
        logic                  old_ok;
        logic [MASK_W-1:0]     cur_mask;
        logic                  fin_load;
        logic                  res_load;
    } ctl_t;

    typedef logic signed [EXC_W-1:0]  exc_t;
    typedef logic signed [FEXC_W-1:0] fexc_t;

    // packed per-station field; bits beyond the register read as zero
    function automatic logic [LIMIT_BITS-1:0] field_of(input logic [REG_W-1:0] r,
                                                      input int s);
        logic [LIMIT_BITS-1:0] f;
        f = '0;
        for (int b = 0; b < LIMIT_BITS; b++) begin
            if (s * LIMIT_BITS + b < REG_W)
            begin
                f[b] = r[s * LIMIT_BITS + b];
            end
        end
        return f;
    endfunction

    // window length, zero read as one
    function automatic logic [LIMIT_BITS-1:0] win_of(input logic [REG_W-1:0] r,
                                                    input int s);
        logic [LIMIT_BITS-1:0] f;
        f = field_of(r, s);
        return (f == '0) ? LIMIT_BITS'(1) : f;
    endfunction

    function automatic logic bit_of(input logic [MASK_W-1:0] m, input int s);
        return (s < MASK_W) ? m[s] : 1'b0;
    endfunction

    function automatic exc_t clamp_exc(input fexc_t v);
        exc_t r;
        if (v < EXC_MIN)
        begin
            r = exc_t'(EXC_MIN);
        end
        else if (v > EXC_MAX)
        begin
            r = exc_t'(EXC_MAX);
        end
        else
        begin
            r = exc_t'(v);
        end
        return r;
    endfunction

    function automatic logic [PEN_W-1:0] sat_add(input logic [PEN_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [PEN_W:0] t;
        t = {1'b0, a} + (PEN_W + 1)'(b);
        return t[PEN_W] ? PEN_MAX : t[PEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/swcp_ram.sv =====
// ============================================================================
// swcp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module swcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write when enabled, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/swcp_ctrl.sv =====
// ============================================================================
// swcp_ctrl
// Request sequencer: job count, window register, mask store addressing and
// result strobe.
// ============================================================================
`default_nettype none

module swcp_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [swcp_pkg::REQ_W-1:0]          req_type,
    input  logic [swcp_pkg::MASK_W-1:0]         upgrade_mask,
    input  logic                                cfg_we,
    input  logic [swcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swcp_pkg::REG_W-1:0]          cfg_data,
    input  logic [swcp_pkg::MASK_W-1:0]         rd_data,
    output logic                                busy,
    output logic [swcp_pkg::REG_W-1:0]          win,
    output swcp_pkg::ctl_t                      ctl,
    output logic                                ram_we,
    output logic [swcp_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [swcp_pkg::MASK_W-1:0]         ram_wdata,
    output logic [swcp_pkg::ADDR_W-1:0]         ram_raddr,
    output logic                                done,
    output logic [swcp_pkg::SEQ_W-1:0]          seq_length,
    output logic [swcp_pkg::STS_W-1:0]          status
);

    import swcp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CUR  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [REQ_W-1:0]      op_reg, op_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [MASK_W-1:0]     cur_mask_reg, cur_mask_next;
    logic                  proc_vld_reg, proc_vld_next;
    logic [STA_W-1:0]      proc_sta_reg, proc_sta_next;
    logic [LIMIT_BITS-1:0] proc_step_reg, proc_step_next;
    logic                  proc_ok_reg, proc_ok_next;
    logic [STS_W-1:0]      sts_pend_reg, sts_pend_next;
    logic [REG_W-1:0]      win_reg;
    logic                  done_reg;
    logic [SEQ_W-1:0]      seq_length_reg;
    logic [STS_W-1:0]      status_reg;

    logic                  accept;
    logic                  walk_iss;
    logic                  fin_iss;
    logic [CNT_W-1:0]      off;
    logic                  old_ok;
    logic                  fin_load;
    logic                  res_load;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // offset back to the leaving position: station window or tail step
    assign walk_iss = (state_reg == S_WALK) && (idx_reg < IDX_W'(STATIONS));
    assign fin_iss  = (state_reg == S_FIN) && (idx_reg != '0);
    assign off      = (state_reg == S_WALK) ? CNT_W'(win_of(win_reg, int'(idx_reg)))
                                            : CNT_W'(idx_reg);
    assign old_ok   = (k_reg >= off);

    // mask store ports
    assign ram_we    = accept && (req_type == REQ_APPEND) && (count_reg != CNT_W'(MAX_JOBS));
    assign ram_waddr = ADDR_W'(count_reg);
    assign ram_wdata = upgrade_mask;
    assign ram_raddr = (state_reg == S_IDLE) ? ADDR_W'(count_reg - CNT_W'(1))
                                             : ADDR_W'(k_reg - off);

    // sequence one request
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        cur_mask_next  = cur_mask_reg;
        proc_vld_next  = 1'b0;
        proc_sta_next  = proc_sta_reg;
        proc_step_next = proc_step_reg;
        proc_ok_next   = proc_ok_reg;
        sts_pend_next  = sts_pend_reg;
        fin_load       = 1'b0;
        res_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req_type;
                    sts_pend_next = STS_OK;
                    case (req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_JOBS))
                            begin
                                sts_pend_next = STS_FULL;
                                res_load      = 1'b1;
                            end
                            else
                            begin
                                cur_mask_next = upgrade_mask;
                                k_next        = count_reg;
                                count_next    = count_reg + CNT_W'(1);
                                idx_next      = '0;
                                state_next    = S_WALK;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_pend_next = STS_EMPTY;
                                res_load      = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg - CNT_W'(1);
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_CUR;
                            end
                        end
                        REQ_FINISH:
                        begin
                            fin_load   = 1'b1;
                            k_next     = count_reg;
                            idx_next   = IDX_W'(LIM_MAX);
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_CUR:
            begin
                // mask of the job being removed
                cur_mask_next = rd_data;
                idx_next      = '0;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (walk_iss)
                begin
                    proc_vld_next = 1'b1;
                    proc_sta_next = idx_reg[STA_W-1:0];
                    proc_ok_next  = old_ok;
                    idx_next      = idx_reg + IDX_W'(1);
                end
                if (proc_vld_reg && (proc_sta_reg == STA_W'(STATIONS - 1)))
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (fin_iss)
                begin
                    proc_vld_next  = 1'b1;
                    proc_step_next = idx_reg[LIMIT_BITS-1:0];
                    proc_ok_next   = old_ok;
                    idx_next       = idx_reg - IDX_W'(1);
                end
                if (proc_vld_reg && (proc_step_reg == LIMIT_BITS'(1)))
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= REQ_APPEND;
            count_reg    <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
            proc_vld_reg <= 1'b0;
            sts_pend_reg <= STS_OK;
            win_reg      <= WIN_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            idx_reg      <= idx_next;
            proc_vld_reg <= proc_vld_next;
            sts_pend_reg <= sts_pend_next;
            done_reg     <= res_load;
            if (cfg_we && (cfg_index == CFG_WIN))
            begin
                win_reg <= cfg_data;
            end
        end
    end

    // payload: mask, pipeline tags, result fields
    always_ff @(posedge clk)
    begin
        cur_mask_reg  <= cur_mask_next;
        proc_sta_reg  <= proc_sta_next;
        proc_step_reg <= proc_step_next;
        proc_ok_reg   <= proc_ok_next;
        if (res_load)
        begin
            seq_length_reg <= SEQ_W'(count_reg);
            status_reg     <= sts_pend_next;
        end
    end

    assign ctl.proc_vld = proc_vld_reg;
    assign ctl.op       = op_reg;
    assign ctl.sta      = proc_sta_reg;
    assign ctl.step     = proc_step_reg;
    assign ctl.old_ok   = proc_ok_reg;
    assign ctl.cur_mask = cur_mask_reg;
    assign ctl.fin_load = fin_load;
    assign ctl.res_load = res_load;

    assign win        = win_reg;
    assign done       = done_reg;
    assign seq_length = seq_length_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ===== design/swcp_exc.sv =====
// ============================================================================
// swcp_exc
// Station datapath: capacity register, per-station excess, running penalty
// and the trailing-window accumulation for finish.
// ============================================================================
`default_nettype none

module swcp_exc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swcp_pkg::REG_W-1:0]     cfg_data,
    input  logic [swcp_pkg::REG_W-1:0]     win,
    input  swcp_pkg::ctl_t                 ctl,
    input  logic [swcp_pkg::MASK_W-1:0]    rd_data,
    output logic [swcp_pkg::PEN_W-1:0]     penalty
);

    import swcp_pkg::*;

    logic [REG_W-1:0] cap_reg;
    exc_t             exc_reg [STATIONS];
    logic [PEN_W-1:0] pen_reg;
    fexc_t            fin_exc_reg [STATIONS];
    fexc_t            fin_exc_next [STATIONS];
    logic [PEN_W-1:0] acc_reg;
    logic [PEN_W-1:0] penalty_reg;

    exc_t             exc_cfg [STATIONS];
    exc_t             e_cur;
    fexc_t            e_ext;
    logic             cur_bit;
    logic             old_bit;
    exc_t             e_app;
    exc_t             e_rem;
    logic [EXC_W-2:0] pos_app;
    logic [EXC_W-2:0] pos_rem;
    logic [PEN_W-1:0] pen_upd;
    logic [SUM_W-1:0] fin_sum;
    logic [PEN_W-1:0] acc_upd;
    logic             cap_wr;
    logic             do_app;
    logic             do_rem;
    logic             do_fin;

    assign cap_wr = cfg_we && (cfg_index == CFG_CAP);
    assign do_app = ctl.proc_vld && (ctl.op == REQ_APPEND);
    assign do_rem = ctl.proc_vld && (ctl.op == REQ_REMOVE);
    assign do_fin = ctl.proc_vld && (ctl.op == REQ_FINISH);

    // shift each excess by old capacity minus new capacity
    always_comb
    begin
        for (int s = 0; s < STATIONS; s++)
        begin
            exc_cfg[s] = clamp_exc(fexc_t'(exc_reg[s])
                                   + FEXC_W'(field_of(cap_reg, s))
                                   - FEXC_W'(field_of(cfg_data, s)));
        end
    end

    // select the station in flight and its entering and leaving bits
    always_comb
    begin
        e_cur   = '0;
        cur_bit = 1'b0;
        old_bit = 1'b0;
        for (int s = 0; s < STATIONS; s++)
        begin
            if (ctl.sta == STA_W'(s))
            begin
                e_cur   = exc_reg[s];
                cur_bit = bit_of(ctl.cur_mask, s);
                old_bit = bit_of(rd_data, s) && ctl.old_ok;
            end
        end
    end

    // append adds then charges; remove refunds then backs out
    assign e_ext   = fexc_t'(e_cur);
    assign e_app   = clamp_exc(e_ext + FEXC_W'(cur_bit) - FEXC_W'(old_bit));
    assign e_rem   = clamp_exc(e_ext - FEXC_W'(cur_bit) + FEXC_W'(old_bit));
    assign pos_app = (e_app > 0) ? e_app[EXC_W-2:0] : '0;
    assign pos_rem = (e_cur > 0) ? e_cur[EXC_W-2:0] : '0;

    always_comb
    begin
        if (do_app)
        begin
            pen_upd = sat_add(pen_reg, SUM_W'(pos_app));
        end
        else if (do_rem)
        begin
            pen_upd = (pen_reg >= PEN_W'(pos_rem)) ? (pen_reg - PEN_W'(pos_rem)) : '0;
        end
        else
        begin
            pen_upd = pen_reg;
        end
    end

    // one tail step: stations whose window reaches this far drop one position
    always_comb
    begin
        fin_sum = '0;
        for (int s = 0; s < STATIONS; s++)
        begin
            fin_exc_next[s] = fin_exc_reg[s];
            if (win_of(win, s) >= ctl.step)
            begin
                fin_exc_next[s] = fin_exc_reg[s]
                                  - FEXC_W'(bit_of(rd_data, s) && ctl.old_ok);
                if (fin_exc_next[s] > 0)
                begin
                    fin_sum = fin_sum + SUM_W'(fin_exc_next[s][EXC_W-2:0]);
                end
            end
        end
    end

    assign acc_upd = sat_add(acc_reg, fin_sum);

    // persistent state: capacities, excesses, running penalty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            pen_reg <= '0;
            for (int s = 0; s < STATIONS; s++)
            begin
                exc_reg[s] <= clamp_exc(-fexc_t'(field_of(CAP_RESET, s)));
            end
        end
        else
        begin
            if (cap_wr)
            begin
                cap_reg <= cfg_data;
                for (int s = 0; s < STATIONS; s++)
                begin
                    exc_reg[s] <= exc_cfg[s];
                end
            end
            else if (do_app || do_rem)
            begin
                pen_reg <= pen_upd;
                for (int s = 0; s < STATIONS; s++)
                begin
                    if (ctl.sta == STA_W'(s))
                    begin
                        exc_reg[s] <= do_app ? e_app : e_rem;
                    end
                end
            end
        end
    end

    // finish scratch copy and result register
    always_ff @(posedge clk)
    begin
        if (ctl.fin_load)
        begin
            acc_reg <= pen_reg;
            for (int s = 0; s < STATIONS; s++)
            begin
                fin_exc_reg[s] <= fexc_t'(exc_reg[s]);
            end
        end
        else if (do_fin)
        begin
            acc_reg <= acc_upd;
            for (int s = 0; s < STATIONS; s++)
            begin
                fin_exc_reg[s] <= fin_exc_next[s];
            end
        end
        if (ctl.res_load)
        begin
            penalty_reg <= do_fin ? acc_upd : pen_upd;
        end
    end

    assign penalty = penalty_reg;

endmodule

`default_nettype wire

// ===== design/sliding_window_capacity_penalty_core.sv =====
// ============================================================================
// sliding_window_capacity_penalty_core
// Incremental window-capacity penalty evaluator over a stored job sequence.
// ============================================================================
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------
//  request   | start, taken if !busy   | req_type, upgrade_mask
//  result    | done, one-cycle strobe  | penalty, seq_length, status
//  config    | cfg_we, no wait         | cfg_index, cfg_data
//
//  Append makes one mask store read per station through the single read port,
//  then strobes. Remove first reads the removed mask, then does the same.
//  Finish makes one store read per tail step, then strobes.
//  Rejected and unused requests strobe in the cycle after acceptance.
//  Reset clears the count and penalty and sets the excesses from the reset
//  capacities at once; no clearing pass. The result cannot be stalled; a new request may start in the strobe cycle.
//
`default_nettype none

`include "sliding_window_capacity_penalty_core_macros.svh"

module sliding_window_capacity_penalty_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [swcp_pkg::REQ_W-1:0]     req_type,
    input  logic [swcp_pkg::MASK_W-1:0]    upgrade_mask,
    input  logic                           cfg_we,
    input  logic [swcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swcp_pkg::REG_W-1:0]     cfg_data,
    output logic                           done,
    output logic [swcp_pkg::PEN_W-1:0]     penalty,
    output logic [swcp_pkg::SEQ_W-1:0]     seq_length,
    output logic [swcp_pkg::STS_W-1:0]     status
);

    import swcp_pkg::*;

    ctl_t              ctl;
    logic [REG_W-1:0]  win;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [MASK_W-1:0] ram_wdata;
    logic [MASK_W-1:0] ram_rdata;

    // job mask store
    swcp_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request sequencer
    swcp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .upgrade_mask (upgrade_mask),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rd_data      (ram_rdata),
        .busy         (busy),
        .win          (win),
        .ctl          (ctl),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .done         (done),
        .seq_length   (seq_length),
        .status       (status)
    );

    // station datapath
    swcp_exc u_exc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win       (win),
        .ctl       (ctl),
        .rd_data   (ram_rdata),
        .penalty   (penalty)
    );

    // checks
    `SWCP_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
    `SWCP_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request dropped")
    `SWCP_ASSERT_SAME(a_full_len, done && (status == STS_FULL), seq_length == SEQ_W'(MAX_JOBS), "full status with store not full")
    `SWCP_ASSERT_SAME(a_empty_len, done && (status == STS_EMPTY), seq_length == '0, "empty status with jobs held")

endmodule

`default_nettype wire

// ===== test/sliding_window_capacity_penalty_core_checker.sv =====
// ----------------------------------------------------------------------------
// Window penalty result checker
// Watches the request, result and register channels of the window penalty
// core. It keeps its own copy of the job store, the station excesses and the
// running penalty, and works out the result of every accepted request. It
// then compares each strobed result field by field with the oldest result
// still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module swcp_result_checker
    import swcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [MASK_W-1:0] upgrade_mask,
    input  logic              cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]  cfg_data,
    input  logic              done,
    input  logic [PEN_W-1:0]  penalty,
    input  logic [SEQ_W-1:0]  seq_length,
    input  logic [STS_W-1:0]  status,
    output int                mismatches,
    output int                outstanding
);

    localparam int PEN_CEIL = 2 ** PEN_W - 1;

    typedef struct packed {
        logic [PEN_W-1:0] penalty;
        logic [SEQ_W-1:0] seq_length;
        logic [STS_W-1:0] status;
    } job_result_t;

    // Own copy of the block's state and registers
    logic [MASK_W-1:0] job_mask_store [MAX_JOBS];
    int                station_exc [STATIONS];
    int                run_pen;
    int                jobs_held;
    logic [REG_W-1:0]  cap_reg;
    logic [REG_W-1:0]  win_reg;

    job_result_t awaited_results [$];
    int          fail_tally;

    // 4-bit station field of a packed register; fields past the top read zero
    function automatic int station_field(input logic [REG_W-1:0] r, input int s);
        if (s * LIMIT_BITS >= REG_W)
        begin
            return 0;
        end
        return int'((r >> (s * LIMIT_BITS)) & LIM_MAX);
    endfunction

    function automatic int window_len(input int s);
        int w;
        w = station_field(win_reg, s);
        return (w == 0) ? 1 : w;
    endfunction

    function automatic int need_bit(input int pos, input int s);
        if (s >= MASK_W)
        begin
            return 0;
        end
        return int'(job_mask_store[pos][s]);
    endfunction

    function automatic int clip_exc(input int v);
        if (v < EXC_MIN)
        begin
            return EXC_MIN;
        end
        if (v > EXC_MAX)
        begin
            return EXC_MAX;
        end
        return v;
    endfunction

    function automatic int add_capped(input int a, input int b);
        return (a + b > PEN_CEIL) ? PEN_CEIL : a + b;
    endfunction

    // Shift the excesses on a capacity change; window changes apply later
    function automatic void take_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [REG_W-1:0] data);
        if (idx == CFG_CAP)
        begin
            for (int s = 0; s < STATIONS; s++)
            begin
                station_exc[s] = clip_exc(station_exc[s] + station_field(cap_reg, s)
                                          - station_field(data, s));
            end
            cap_reg = data;
        end
        else if (idx == CFG_WIN)
        begin
            win_reg = data;
        end
    endfunction

    // Apply one request to the sequence and return the result it produces
    function automatic job_result_t advance_sequence(input logic [REQ_W-1:0] req,
                                                     input logic [MASK_W-1:0] mask);
        job_result_t r;
        int          k;
        int          w;
        int          e;
        int          total;
        r.status = STS_OK;
        total    = -1;
        case (req)
            REQ_APPEND:
            begin
                if (jobs_held >= MAX_JOBS)
                begin
                    r.status = STS_FULL;
                end
                else
                begin
                    k = jobs_held;
                    job_mask_store[k] = mask;
                    for (int s = 0; s < STATIONS; s++)
                    begin
                        w = window_len(s);
                        e = station_exc[s] + need_bit(k, s);
                        if (k >= w)
                        begin
                            e -= need_bit(k - w, s);
                        end
                        e = clip_exc(e);
                        station_exc[s] = e;
                        if (e > 0)
                        begin
                            run_pen = add_capped(run_pen, e);
                        end
                    end
                    jobs_held = k + 1;
                end
            end
            REQ_REMOVE:
            begin
                if (jobs_held == 0)
                begin
                    r.status = STS_EMPTY;
                end
                else
                begin
                    k = jobs_held - 1;
                    for (int s = 0; s < STATIONS; s++)
                    begin
                        w = window_len(s);
                        e = station_exc[s];
                        // floor at zero: no exact undo once saturated
                        if (e > 0)
                        begin
                            run_pen = (run_pen >= e) ? run_pen - e : 0;
                        end
                        e -= need_bit(k, s);
                        if (k >= w)
                        begin
                            e += need_bit(k - w, s);
                        end
                        station_exc[s] = clip_exc(e);
                    end
                    jobs_held = k;
                end
            end
            REQ_FINISH:
            begin
                // walk the shrinking tail windows without touching the state
                total = run_pen;
                for (int s = 0; s < STATIONS; s++)
                begin
                    w = window_len(s);
                    e = station_exc[s];
                    for (int i = 0; i < w; i++)
                    begin
                        if (jobs_held + i >= w)
                        begin
                            e -= need_bit(jobs_held + i - w, s);
                        end
                        if (e > 0)
                        begin
                            total = add_capped(total, e);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.penalty    = PEN_W'((total >= 0) ? total : run_pen);
        r.seq_length = SEQ_W'(jobs_held);
        return r;
    endfunction

    // Track registers, compare results, then queue the new request's result
    always @(posedge clk or negedge rst_n)
    begin
        job_result_t want;
        if (!rst_n)
        begin
            cap_reg = CAP_RESET;
            win_reg = WIN_RESET;
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                job_mask_store[i] = '0;
            end
            for (int s = 0; s < STATIONS; s++)
            begin
                station_exc[s] = clip_exc(-station_field(CAP_RESET, s));
            end
            run_pen    = 0;
            jobs_held  = 0;
            fail_tally = 0;
            awaited_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                take_register_write(cfg_index, cfg_data);
            end
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (fail_tally < 10)
                    begin
                        $display("unexpected result: penalty=%0d seq_length=%0d status=%0d",
                                 penalty, seq_length, status);
                    end
                    fail_tally++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.penalty !== penalty || want.seq_length !== seq_length
                        || want.status !== status)
                    begin
                        if (fail_tally < 10)
                        begin
                            $display("result mismatch: expected penalty=%0d seq_length=%0d %s",
                                     want.penalty, want.seq_length,
                                     $sformatf("status=%0d, got penalty=%0d seq_length=%0d status=%0d",
                                               want.status, penalty, seq_length, status));
                        end
                        fail_tally++;
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_results.insert(awaited_results.size(),
                                       advance_sequence(req_type, upgrade_mask));
            end
            outstanding <= awaited_results.size();
            mismatches  <= fail_tally;
        end
    end

endmodule

// ===== test/sliding_window_capacity_penalty_core_test.sv =====
// ----------------------------------------------------------------------------
// Window penalty core testbench
// Drives job sequences into the core: a directed opening over the empty
// store, the unused request code, a capacity change under held jobs and the
// remove floor, then random phases under changing capacities and windows with
// a fill up to the store limit. The checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_capacity_penalty_core_test;

    import swcp_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_ITEMS    = 10;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [REQ_W-1:0]     req_type     = '0;
    logic [MASK_W-1:0]    upgrade_mask = '0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [REG_W-1:0]     cfg_data     = '0;
    logic                 busy;
    logic                 done;
    logic [PEN_W-1:0]     penalty;
    logic [SEQ_W-1:0]     seq_length;
    logic [STS_W-1:0]     status;

    int               mismatches;
    int               outstanding;
    int               cycle_count  = 0;
    int               held_jobs    = 0;
    logic             idling       = 1'b1;

    sliding_window_capacity_penalty_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .upgrade_mask (upgrade_mask),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .penalty      (penalty),
        .seq_length   (seq_length),
        .status       (status)
    );

    swcp_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .upgrade_mask (upgrade_mask),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .penalty      (penalty),
        .seq_length   (seq_length),
        .status       (status),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Issue one request after an optional gap and hold it until taken
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [MASK_W-1:0] mask);
        int gap;
        gap = 0;
        if (idling)
        begin
            while ($urandom_range(99) < 35)
            begin
                gap++;
            end
            if ($urandom_range(15) == 0)
            begin
                gap += $urandom_range(24, 1);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= req;
        upgrade_mask <= mask;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (req == REQ_APPEND && held_jobs < MAX_JOBS)
        begin
            held_jobs++;
        end
        else if (req == REQ_REMOVE && held_jobs > 0)
        begin
            held_jobs--;
        end
    endtask

    // Drop start and wait until every awaited result has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Requirement mask at one of four densities
    function automatic logic [MASK_W-1:0] draw_mask(input int density);
        case (density)
            0: return MASK_W'($urandom & $urandom);
            1: return MASK_W'($urandom);
            2: return MASK_W'($urandom | $urandom);
            default: return '1;
        endcase
    endfunction

    // Register value: an extreme, the reset value or random
    function automatic logic [REG_W-1:0] draw_setting(input logic [REG_W-1:0] reset_val);
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return reset_val;
            default: return REG_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int   density;
        int   pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, unused code, then a short sequence at reset settings
        send_request(REQ_FINISH, 5'h00);
        send_request(REQ_REMOVE, 5'h1F);
        send_request(REQ_UNUSED, 5'h1F);
        send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_APPEND, 5'h00);
        send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_FINISH, 5'h00);
        send_request(REQ_REMOVE, 5'h00);
        send_request(REQ_UNUSED, 5'h00);

        // Highest capacity under held jobs: excesses drop, nothing is added
        write_register(CFG_CAP, '1);
        write_register(CFG_WIN, '1);
        repeat (3) send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_FINISH, 5'h00);

        // Zero capacity lifts the excesses above the penalty: remove floors at zero
        write_register(CFG_CAP, '0);
        send_request(REQ_REMOVE, 5'h00);
        send_request(REQ_FINISH, 5'h00);

        // Zero windows act as one
        write_register(CFG_WIN, '0);
        send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_APPEND, 5'h1F);
        send_request(REQ_FINISH, 5'h00);
        send_request(REQ_APPEND, 5'h10);
        send_request(REQ_REMOVE, 5'h00);

        // Random phases; settings change with jobs still held
        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(CFG_CAP, draw_setting(CAP_RESET));
            write_register(CFG_WIN, draw_setting(WIN_RESET));
            density = $urandom_range(3);
            if (phase == 5)
            begin
                // fill to the store limit, the first half back to back, and push against it
                while (held_jobs < MAX_JOBS)
                begin
                    idling = (held_jobs >= MAX_JOBS / 2);
                    send_request(REQ_APPEND, draw_mask(density));
                end
                idling = 1'b1;
                repeat (3) send_request(REQ_APPEND, draw_mask(1));
                send_request(REQ_FINISH, draw_mask(1));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    send_request(REQ_APPEND, draw_mask(density));
                end
                else if (pick < 75)
                begin
                    send_request(REQ_REMOVE, draw_mask(1));
                end
                else if (pick < 92)
                begin
                    send_request(REQ_FINISH, draw_mask(1));
                end
                else
                begin
                    send_request(REQ_UNUSED, draw_mask(1));
                end
            end
        end
        send_request(REQ_FINISH, 5'h00);

        // Drain and give the verdict
        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
